@@ rtl/wavhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants for the WAV header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam int unsigned STATUS_W = 3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd4;

  // Four-character codes as little-endian words.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] DEFAULT_MAX_RATE = 32'd384000;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  // Register byte addresses.
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_MAX_RATE = 3'd0;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [15:0]         audio_format;
    logic [15:0]         channel_count;
    logic [31:0]         sample_rate;
    logic [15:0]         bits_per_sample;
    logic [31:0]         data_position;
    logic [31:0]         data_size;
  } result_t;

endpackage

@@ rtl/wavhp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_in_if
// Byte channel into the WAV header parser.
// ----------------------------------------------------------------------------
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

@@ rtl/wavhp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_out_if
// Result channel out of the WAV header parser.
// ----------------------------------------------------------------------------
interface wavhp_out_if;
  logic                          valid;
  logic                          ready;
  logic [wavhp_pkg::STATUS_W-1:0] status;
  logic [15:0]                   audio_format;
  logic [15:0]                   channel_count;
  logic [31:0]                   sample_rate;
  logic [15:0]                   bits_per_sample;
  logic [31:0]                   data_position;
  logic [31:0]                   data_size;

  modport source (output valid, status, audio_format, channel_count, sample_rate,
                  bits_per_sample, data_position, data_size, input ready);
  modport sink   (input valid, status, audio_format, channel_count, sample_rate,
                  bits_per_sample, data_position, data_size, output ready);
endinterface

@@ rtl/wavhp_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_check
// Final format, rate and channel checks on the captured fmt fields.
// ----------------------------------------------------------------------------
module wavhp_check (
  input  logic [15:0]                    audio_format,
  input  logic [15:0]                    channel_count,
  input  logic [31:0]                    sample_rate,
  input  logic [15:0]                    bits_per_sample,
  input  logic [31:0]                    max_rate,
  output logic [wavhp_pkg::STATUS_W-1:0] status
);

  logic fmt_ok;

  always_comb begin
    fmt_ok = ((audio_format == wavhp_pkg::FMT_PCM) &&
              (bits_per_sample == 16'd16 || bits_per_sample == 16'd24)) ||
             ((audio_format == wavhp_pkg::FMT_FLOAT) && (bits_per_sample == 16'd32));
    if (!fmt_ok) begin
      status = wavhp_pkg::ST_UNSUPPORTED;
    end else if (sample_rate == 32'd0 || sample_rate > max_rate ||
                 channel_count == 16'd0) begin
      status = wavhp_pkg::ST_INVALID;
    end else begin
      status = wavhp_pkg::ST_OK;
    end
  end

endmodule

@@ rtl/wav_header_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser_unit
// Byte-serial RIFF/WAVE header parser that reports format and data chunk.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output register is empty or draining;
// the parse state advances at the edge that accepts a byte, and the byte-wide
// next-state logic sets that figure. A result beat becomes valid in the cycle
// after the byte or end marker that completes it, held in a single output register.
// Reset: rst_n is synchronous and active low; it returns the parser to the
// RIFF tag phase, empties the output register and sets max_rate_r to 384000.
module wav_header_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  wavhp_in_if.sink                      in_ch,
  wavhp_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wavhp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Parse phases. Skip counts down the body of an ignored chunk or the extra
  // fmt bytes; done holds after a result until an end marker rearms the parser.
  localparam logic [3:0] PH_RIFF    = 4'd0;
  localparam logic [3:0] PH_RSIZE   = 4'd1;
  localparam logic [3:0] PH_WAVE    = 4'd2;
  localparam logic [3:0] PH_CID     = 4'd3;
  localparam logic [3:0] PH_CSIZE   = 4'd4;
  localparam logic [3:0] PH_FFORMAT = 4'd5;
  localparam logic [3:0] PH_FCHAN   = 4'd6;
  localparam logic [3:0] PH_FRATE   = 4'd7;
  localparam logic [3:0] PH_FBRATE  = 4'd8;
  localparam logic [3:0] PH_FALIGN  = 4'd9;
  localparam logic [3:0] PH_FBITS   = 4'd10;
  localparam logic [3:0] PH_SKIP    = 4'd11;
  localparam logic [3:0] PH_DONE    = 4'd12;

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        seen_fmt_r, seen_fmt_nxt;
  logic        seen_data_r, seen_data_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dpos_r, dpos_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] max_rate_r, max_rate_nxt;

  logic                 out_valid_r, out_valid_nxt;
  wavhp_pkg::result_t   res_r, res_nxt;

  logic                 in_acc;
  logic                 cfg_wr;
  logic [31:0]          pos_inc;
  logic [31:0]          value;
  logic                 field_done;
  logic                 two_byte;
  logic [32:0]          chunk_skip;
  logic                 emit_err;
  logic                 emit_fin;
  logic [wavhp_pkg::STATUS_W-1:0] err_status;
  logic [wavhp_pkg::STATUS_W-1:0] fin_status;
  logic [15:0]          fin_bits;
  logic [31:0]          fin_pos;
  logic [31:0]          fin_size;

  // A byte can enter whenever the output register is empty or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // The configuration port has no wait states; one register lives at
  // address zero and the upper half of the window reads as zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'd0 : max_rate_r;

  always_comb begin
    max_rate_nxt = max_rate_r;
    if (cfg_wr && paddr[2] == wavhp_pkg::REG_MAX_RATE[2]) begin
      max_rate_nxt = pwdata;
    end
  end

  // The incoming byte is merged into the partial little-endian field.
  assign pos_inc = pos_r + 32'd1;
  always_comb begin
    value = word_r;
    case (cnt_r)
      2'd0:    value[7:0]   = in_ch.data_byte;
      2'd1:    value[15:8]  = in_ch.data_byte;
      2'd2:    value[23:16] = in_ch.data_byte;
      2'd3:    value[31:24] = in_ch.data_byte;
      default: value = word_r;
    endcase
  end

  assign two_byte   = (phase_r == PH_FFORMAT) || (phase_r == PH_FCHAN) ||
                      (phase_r == PH_FALIGN) || (phase_r == PH_FBITS);
  assign field_done = two_byte ? (cnt_r == 2'd1) : (cnt_r == 2'd3);

  // Body length of a skipped chunk, rounded up to an even byte count.
  assign chunk_skip = {1'b0, value} + {32'd0, value[0]};

  // The final checks see the bits field as it completes at the end of the
  // fmt chunk, or the stored value when the data chunk completes the parse.
  assign fin_bits = (phase_r == PH_FBITS) ? value[15:0] : bits_r;
  assign fin_pos  = (phase_r == PH_CSIZE) ? pos_inc : dpos_r;
  assign fin_size = (phase_r == PH_CSIZE) ? value : dsize_r;

  wavhp_check u_check (
    .audio_format    (fmt_r),
    .channel_count   (chan_r),
    .sample_rate     (rate_r),
    .bits_per_sample (fin_bits),
    .max_rate        (max_rate_r),
    .status          (fin_status)
  );

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    tag_nxt       = tag_r;
    skip_nxt      = skip_r;
    pos_nxt       = pos_r;
    seen_fmt_nxt  = seen_fmt_r;
    seen_data_nxt = seen_data_r;
    fmt_nxt       = fmt_r;
    chan_nxt      = chan_r;
    rate_nxt      = rate_r;
    bits_nxt      = bits_r;
    dpos_nxt      = dpos_r;
    dsize_nxt     = dsize_r;
    emit_err      = 1'b0;
    emit_fin      = 1'b0;
    err_status    = wavhp_pkg::ST_BAD_HEADER;

    if (in_acc && in_ch.end_of_stream) begin
      // An end marker always clears the parse. Before a result it reports
      // a truncated numeric field or a missing or broken header.
      if (phase_r != PH_DONE) begin
        emit_err = 1'b1;
        if (phase_r == PH_RSIZE || phase_r == PH_CSIZE ||
            (phase_r >= PH_FFORMAT && phase_r <= PH_FBITS)) begin
          err_status = wavhp_pkg::ST_TRUNCATED;
        end
      end
      phase_nxt     = PH_RIFF;
      cnt_nxt       = 2'd0;
      word_nxt      = 32'd0;
      tag_nxt       = 32'd0;
      skip_nxt      = 33'd0;
      pos_nxt       = 32'd0;
      seen_fmt_nxt  = 1'b0;
      seen_data_nxt = 1'b0;
      fmt_nxt       = 16'd0;
      chan_nxt      = 16'd0;
      rate_nxt      = 32'd0;
      bits_nxt      = 16'd0;
      dpos_nxt      = 32'd0;
      dsize_nxt     = 32'd0;
    end else if (in_acc && phase_r != PH_DONE) begin
      pos_nxt = pos_inc;
      if (phase_r == PH_SKIP) begin
        skip_nxt = skip_r - 33'd1;
        if (skip_r == 33'd1) begin
          phase_nxt = PH_CID;
        end
      end else if (!field_done) begin
        word_nxt = value;
        cnt_nxt  = cnt_r + 2'd1;
      end else begin
        word_nxt = 32'd0;
        cnt_nxt  = 2'd0;
        case (phase_r)
          PH_RIFF: begin
            if (value != wavhp_pkg::TAG_RIFF) begin
              emit_err  = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_RSIZE;
            end
          end
          PH_RSIZE: begin
            phase_nxt = PH_WAVE;
          end
          PH_WAVE: begin
            if (value != wavhp_pkg::TAG_WAVE) begin
              emit_err  = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_CID;
            end
          end
          PH_CID: begin
            tag_nxt   = value;
            phase_nxt = PH_CSIZE;
          end
          PH_CSIZE: begin
            if (tag_r == wavhp_pkg::TAG_FMT) begin
              // Extra fmt bytes past the basic 16 are skipped unpadded.
              seen_fmt_nxt = 1'b1;
              skip_nxt     = (value > 32'd16) ? {1'b0, value - 32'd16} : 33'd0;
              phase_nxt    = PH_FFORMAT;
            end else if (tag_r == wavhp_pkg::TAG_DATA && seen_fmt_r) begin
              seen_data_nxt = 1'b1;
              dpos_nxt      = pos_inc;
              dsize_nxt     = value;
              emit_fin      = 1'b1;
              phase_nxt     = PH_DONE;
            end else begin
              if (tag_r == wavhp_pkg::TAG_DATA) begin
                seen_data_nxt = 1'b1;
                dpos_nxt      = pos_inc;
                dsize_nxt     = value;
              end
              skip_nxt  = chunk_skip;
              phase_nxt = (chunk_skip == 33'd0) ? PH_CID : PH_SKIP;
            end
          end
          PH_FFORMAT: begin
            fmt_nxt   = value[15:0];
            phase_nxt = PH_FCHAN;
          end
          PH_FCHAN: begin
            chan_nxt  = value[15:0];
            phase_nxt = PH_FRATE;
          end
          PH_FRATE: begin
            rate_nxt  = value;
            phase_nxt = PH_FBRATE;
          end
          PH_FBRATE: begin
            phase_nxt = PH_FALIGN;
          end
          PH_FALIGN: begin
            phase_nxt = PH_FBITS;
          end
          PH_FBITS: begin
            bits_nxt = value[15:0];
            if (seen_data_r) begin
              emit_fin  = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = (skip_r == 33'd0) ? PH_CID : PH_SKIP;
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  // Output register: loaded with a result beat, cleared once it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (out_ch.ready || !out_valid_r) begin
      out_valid_nxt = emit_err || emit_fin;
    end
    if (emit_fin) begin
      res_nxt.status          = fin_status;
      res_nxt.audio_format    = fmt_r;
      res_nxt.channel_count   = chan_r;
      res_nxt.sample_rate     = rate_r;
      res_nxt.bits_per_sample = fin_bits;
      res_nxt.data_position   = fin_pos;
      res_nxt.data_size       = fin_size;
    end else if (emit_err) begin
      res_nxt                 = '0;
      res_nxt.status          = err_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      cnt_r       <= 2'd0;
      word_r      <= 32'd0;
      tag_r       <= 32'd0;
      skip_r      <= 33'd0;
      pos_r       <= 32'd0;
      seen_fmt_r  <= 1'b0;
      seen_data_r <= 1'b0;
      fmt_r       <= 16'd0;
      chan_r      <= 16'd0;
      rate_r      <= 32'd0;
      bits_r      <= 16'd0;
      dpos_r      <= 32'd0;
      dsize_r     <= 32'd0;
      max_rate_r  <= wavhp_pkg::DEFAULT_MAX_RATE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      word_r      <= word_nxt;
      tag_r       <= tag_nxt;
      skip_r      <= skip_nxt;
      pos_r       <= pos_nxt;
      seen_fmt_r  <= seen_fmt_nxt;
      seen_data_r <= seen_data_nxt;
      fmt_r       <= fmt_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      dpos_r      <= dpos_nxt;
      dsize_r     <= dsize_nxt;
      max_rate_r  <= max_rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = res_r.status;
  assign out_ch.audio_format    = res_r.audio_format;
  assign out_ch.channel_count   = res_r.channel_count;
  assign out_ch.sample_rate     = res_r.sample_rate;
  assign out_ch.bits_per_sample = res_r.bits_per_sample;
  assign out_ch.data_position   = res_r.data_position;
  assign out_ch.data_size       = res_r.data_size;

  // An end marker always leaves the parser at the start of a fresh file.
  a_eos_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.end_of_stream) |=> (phase_r == PH_RIFF && pos_r == 32'd0))
    else $error("end marker did not rearm the parser");

  // A new result beat only appears after an accepted input beat.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(in_acc))
    else $error("result beat without an accepted input beat");

  // Once reported, file bytes no longer move the byte position.
  a_done_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && in_acc && !in_ch.end_of_stream) |=> $stable(pos_r))
    else $error("byte position moved after the result");

  // A success status always carries a supported format tag.
  a_ok_format: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == wavhp_pkg::ST_OK) |->
      (res_r.audio_format == wavhp_pkg::FMT_PCM ||
       res_r.audio_format == wavhp_pkg::FMT_FLOAT))
    else $error("ok status with an unsupported format");

endmodule

@@ tb/wav_header_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser_unit_tb
// Self-checking bench for the byte-serial WAV header parser. Byte beats and
// end markers go in over a valid/ready channel, and an in-bench parser
// predicts every result beat, which is compared field by field. The max rate
// register is rewritten over the APB port between runs of files.
// ----------------------------------------------------------------------------
module wav_header_parser_unit_tb;
  import wavhp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned FILE_BEATS_PER_RUN = 150;
  localparam int unsigned FILES_PER_RUN = 3;

  // Parse phases of the predictor, in the order the header is walked.
  typedef enum logic [4:0] {
    P_RIFF_TAG, P_RIFF_SIZE, P_WAVE_TAG, P_CHUNK_ID, P_CHUNK_SIZE,
    P_FMT_FORMAT, P_FMT_CHANNELS, P_FMT_RATE, P_FMT_BYTE_RATE, P_FMT_ALIGN,
    P_FMT_BITS, P_SKIP, P_DONE
  } parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } byte_beat_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wavhp_in_if  in_ch ();
  wavhp_out_if out_ch ();

  wav_header_parser_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Beats waiting to be offered, and header results the parser still owes.
  byte_beat_t  pending_beats[$];
  result_t     expected_headers[$];
  logic [7:0]  file_img[$];

  int unsigned fail_count = 0;
  int unsigned accepted_beats = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 0;

  // Predictor state: a private copy of the parser and of its register.
  logic [31:0]  max_rate;
  parse_phase_t ph;
  logic [2:0]   nbytes;
  logic [31:0]  acc;
  logic [31:0]  chunk_id;
  logic [32:0]  skip_left;
  logic [31:0]  file_pos;
  bit           got_fmt;
  bit           got_data;
  logic [15:0]  fmt_tag;
  logic [15:0]  chan_cnt;
  logic [31:0]  srate;
  logic [15:0]  sbits;
  logic [31:0]  dpos;
  logic [31:0]  dsize;
  bit           reported_flag;

  // Random gaps on both sides, except in a calm window where every cycle
  // carries a beat if one is available.
  function automatic bit calm_window();
    return accepted_beats >= 600 && accepted_beats < 800;
  endfunction

  // --------------------------------------------------------------------------
  // Header predictor
  // --------------------------------------------------------------------------

  function automatic void clear_parse();
    ph            = P_RIFF_TAG;
    nbytes        = '0;
    acc           = '0;
    chunk_id      = '0;
    skip_left     = '0;
    file_pos      = '0;
    got_fmt       = 1'b0;
    got_data      = 1'b0;
    fmt_tag       = '0;
    chan_cnt      = '0;
    srate         = '0;
    sbits         = '0;
    dpos          = '0;
    dsize         = '0;
    reported_flag = 1'b0;
  endfunction

  // An error result carries only its status; the parser then ignores bytes.
  function automatic bit stop_with(input logic [STATUS_W-1:0] code, output result_t r);
    r             = '0;
    r.status      = code;
    reported_flag = 1'b1;
    ph            = P_DONE;
    return 1'b1;
  endfunction

  // Both chunks have been seen: judge the captured format and report it.
  function automatic bit final_result(output result_t r);
    bit fmt_ok;
    fmt_ok = (fmt_tag == FMT_PCM && (sbits == 16'd16 || sbits == 16'd24)) ||
             (fmt_tag == FMT_FLOAT && sbits == 16'd32);
    r = '0;
    if (!fmt_ok)
      r.status = ST_UNSUPPORTED;
    else if (srate == 0 || srate > max_rate || chan_cnt == 0)
      r.status = ST_INVALID;
    else
      r.status = ST_OK;
    r.audio_format    = fmt_tag;
    r.channel_count   = chan_cnt;
    r.sample_rate     = srate;
    r.bits_per_sample = sbits;
    r.data_position   = dpos;
    r.data_size       = dsize;
    reported_flag     = 1'b1;
    ph                = P_DONE;
    return 1'b1;
  endfunction

  function automatic void start_skip(input logic [32:0] n);
    skip_left = n;
    ph = (n == 0) ? P_CHUNK_ID : P_SKIP;
  endfunction

  // Advances the predictor by one accepted beat; returns 1 when that beat
  // completes a header result, which is then returned in r.
  function automatic bit parse_byte(input logic [7:0] b, input logic eos, output result_t r);
    logic [31:0] word;
    bit          numeric;
    bit          two_byte;
    r = '0;
    if (eos) begin
      // An end marker inside a size or fmt field means the field was cut
      // short; anywhere else a chunk is simply missing.
      numeric = ph == P_RIFF_SIZE || ph == P_CHUNK_SIZE ||
                (ph >= P_FMT_FORMAT && ph <= P_FMT_BITS);
      if (!reported_flag) begin
        void'(stop_with(numeric ? ST_TRUNCATED : ST_BAD_HEADER, r));
        clear_parse();
        return 1'b1;
      end
      clear_parse();
      return 1'b0;
    end
    if (reported_flag || ph == P_DONE)
      return 1'b0;
    file_pos = file_pos + 32'd1;
    if (ph == P_SKIP) begin
      skip_left = skip_left - 33'd1;
      if (skip_left == 0)
        ph = P_CHUNK_ID;
      return 1'b0;
    end
    acc      = acc | (32'(b) << (8 * nbytes));
    nbytes   = nbytes + 3'd1;
    two_byte = ph == P_FMT_FORMAT || ph == P_FMT_CHANNELS ||
               ph == P_FMT_ALIGN || ph == P_FMT_BITS;
    if (nbytes < (two_byte ? 3'd2 : 3'd4))
      return 1'b0;
    word   = acc;
    acc    = '0;
    nbytes = '0;
    case (ph)
      P_RIFF_TAG: begin
        if (word != TAG_RIFF)
          return stop_with(ST_BAD_HEADER, r);
        ph = P_RIFF_SIZE;
      end
      P_RIFF_SIZE: ph = P_WAVE_TAG;
      P_WAVE_TAG: begin
        if (word != TAG_WAVE)
          return stop_with(ST_BAD_HEADER, r);
        ph = P_CHUNK_ID;
      end
      P_CHUNK_ID: begin
        chunk_id = word;
        ph = P_CHUNK_SIZE;
      end
      P_CHUNK_SIZE: begin
        if (chunk_id == TAG_FMT) begin
          // Only the first 16 bytes are parsed; the rest is skipped unpadded.
          got_fmt   = 1'b1;
          skip_left = (word > 32'd16) ? {1'b0, word - 32'd16} : 33'd0;
          ph        = P_FMT_FORMAT;
        end else begin
          if (chunk_id == TAG_DATA) begin
            got_data = 1'b1;
            dpos     = file_pos;
            dsize    = word;
            if (got_fmt)
              return final_result(r);
          end
          // Data and unknown chunks are padded to an even length.
          start_skip({1'b0, word} + 33'(word[0]));
        end
      end
      P_FMT_FORMAT: begin
        fmt_tag = word[15:0];
        ph = P_FMT_CHANNELS;
      end
      P_FMT_CHANNELS: begin
        chan_cnt = word[15:0];
        ph = P_FMT_RATE;
      end
      P_FMT_RATE: begin
        srate = word;
        ph = P_FMT_BYTE_RATE;
      end
      P_FMT_BYTE_RATE: ph = P_FMT_ALIGN;
      P_FMT_ALIGN: ph = P_FMT_BITS;
      P_FMT_BITS: begin
        sbits = word[15:0];
        if (got_data)
          return final_result(r);
        start_skip(skip_left);
      end
      default: ph = P_DONE;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // File builder
  // --------------------------------------------------------------------------

  function automatic void add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++)
      file_img.push_back(v[8*i +: 8]);
  endfunction

  function automatic void send_image(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      pending_beats.push_back('{file_img[i], 1'b0});
  endfunction

  // One fmt chunk with field values aimed at every status. A huge chunk size
  // is only used once the data chunk is behind us, since the result then
  // comes before any extra bytes would have to be skipped.
  function automatic void add_fmt_chunk(input bit data_seen);
    logic [31:0] fsz;
    logic [31:0] rate_v;
    logic [15:0] fmt_v;
    logic [15:0] chans_v;
    logic [15:0] bits_v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: fsz = 32'd16;
      6, 7:             fsz = $urandom_range(20, 17);
      8:                fsz = $urandom_range(15, 0);
      default:          fsz = data_seen ? 32'hFFFF_FFFF - $urandom_range(3) : 32'd16;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: fmt_v = FMT_PCM;
      5, 6, 7:       fmt_v = FMT_FLOAT;
      8:             fmt_v = 16'($urandom);
      default:       fmt_v = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6, 7: chans_v = 16'($urandom_range(8, 1));
      8:                      chans_v = 16'd0;
      default:                chans_v = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
    endcase
    // Rates cluster around the current limit so both sides of it are hit.
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: rate_v = $urandom_range(max_rate, 1);
      6:                rate_v = max_rate;
      7:                rate_v = max_rate + 32'd1;
      8:                rate_v = 32'd0;
      default:          rate_v = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
    endcase
    if ($urandom_range(9) < 7)
      bits_v = (fmt_v == FMT_FLOAT) ? 16'd32 : ($urandom_range(1) ? 16'd16 : 16'd24);
    else
      case ($urandom_range(4))
        0:       bits_v = 16'd8;
        1:       bits_v = 16'd32;
        2:       bits_v = 16'd0;
        3:       bits_v = 16'hFFFF;
        default: bits_v = 16'($urandom);
      endcase
    add_le(TAG_FMT, 4);
    add_le(fsz, 4);
    add_le(32'(fmt_v), 2);
    add_le(32'(chans_v), 2);
    add_le(rate_v, 4);
    add_le($urandom, 4);
    add_le($urandom, 2);
    add_le(32'(bits_v), 2);
    if (!data_seen && fsz > 32'd16)
      repeat (fsz - 32'd16) file_img.push_back(8'($urandom));
  endfunction

  // Queues one file closed by an end marker, so each file owes exactly one
  // result. Most files are well formed with random content; some have a bit flipped,
  // some are cut short and some are noise. Returns the beats that count.
  function automatic int unsigned add_file();
    int unsigned kind;
    int unsigned keep;
    int unsigned pos;
    logic [31:0] jsz;
    logic [31:0] dsz;
    bit          data_first;
    file_img.delete();
    kind = $urandom_range(99);
    if (kind >= 90) begin
      if ($urandom_range(1))
        add_le(TAG_RIFF, 4);
      repeat ($urandom_range(8)) file_img.push_back(8'($urandom));
    end else begin
      add_le(TAG_RIFF, 4);
      add_le($urandom, 4);
      add_le(TAG_WAVE, 4);
      // Unknown chunks ahead of the ones we care about, odd sizes padded.
      repeat (($urandom_range(9) < 6) ? 0 : $urandom_range(2, 1)) begin
        jsz = $urandom_range(5);
        add_le($urandom, 4);
        add_le(jsz, 4);
        repeat (jsz + jsz[0]) file_img.push_back(8'($urandom));
      end
      data_first = $urandom_range(3) == 0;
      if (data_first) begin
        dsz = $urandom_range(6);
        add_le(TAG_DATA, 4);
        add_le(dsz, 4);
        repeat (dsz + dsz[0]) file_img.push_back(8'($urandom));
        add_fmt_chunk(1'b1);
      end else begin
        add_fmt_chunk(1'b0);
        // A second fmt chunk overwrites what the first one captured.
        if ($urandom_range(9) == 0)
          add_fmt_chunk(1'b0);
        case ($urandom_range(3))
          0:       dsz = 32'd0;
          1:       dsz = 32'hFFFF_FFFF;
          default: dsz = $urandom;
        endcase
        add_le(TAG_DATA, 4);
        add_le(dsz, 4);
      end
      if (kind >= 80) begin
        pos = $urandom_range(file_img.size() - 1);
        file_img[pos] = file_img[pos] ^ (8'd1 << $urandom_range(7));
      end
    end
    keep = file_img.size();
    if (kind < 80 && $urandom_range(5) == 0)
      keep = $urandom_range(file_img.size() - 1);
    send_image(keep);
    // Bytes past the end of the header; usually ignored by the parser.
    repeat ($urandom_range(3)) pending_beats.push_back('{8'($urandom), 1'b0});
    pending_beats.push_back('{8'($urandom), 1'b1});
    return keep + 1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking helpers
  // --------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Any cycle that moves a beat on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("wav_header_parser_unit_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Byte driver: pops the next beat whenever the channel is free, and idles
  // on about one cycle in six outside the calm window.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : drive_bytes
    byte_beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_beats.size() != 0 && (calm_window() || $urandom_range(99) >= 17)) begin
        nxt = pending_beats.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= nxt.data;
        in_ch.end_of_stream <= nxt.eos;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: feeds every accepted byte beat to the predictor, checks every
  // accepted result beat against the oldest expectation and drives ready.
  // Prediction runs first, so the check never depends on block order.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : watch_results
    result_t want;
    result_t got;
    bit      made;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        made = parse_byte(in_ch.data_byte, in_ch.end_of_stream, want);
        if (made)
          expected_headers.push_back(want);
        accepted_beats++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status          = out_ch.status;
        got.audio_format    = out_ch.audio_format;
        got.channel_count   = out_ch.channel_count;
        got.sample_rate     = out_ch.sample_rate;
        got.bits_per_sample = out_ch.bits_per_sample;
        got.data_position   = out_ch.data_position;
        got.data_size       = out_ch.data_size;
        if (expected_headers.size() == 0) begin
          note_failure($sformatf("result beat with none expected, status %0d", got.status));
        end else begin
          want = expected_headers.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("audio_format", 32'(want.audio_format), 32'(got.audio_format));
          check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
          check_field("sample_rate", want.sample_rate, got.sample_rate);
          check_field("bits_per_sample", 32'(want.bits_per_sample),
                      32'(got.bits_per_sample));
          check_field("data_position", want.data_position, got.data_position);
          check_field("data_size", want.data_size, got.data_size);
        end
      end
      // Once, with plenty of bytes queued, the receiver holds off for a long
      // stretch so the output register fills and the parser stalls its input.
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_used && accepted_beats >= 400 && pending_beats.size() > 50) begin
        hold_used = 1'b1;
        hold_left = 300;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm_window() || $urandom_range(99) >= 17;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and run control
  // --------------------------------------------------------------------------

  // Blocks until every queued beat is in and every result is out, then lets
  // the clock run on in case the last beat was an end marker with no result.
  task automatic wait_idle();
    do
      @(posedge clk);
    while (pending_beats.size() != 0 || in_ch.valid || expected_headers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_rate(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_RATE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_rate = value;
  endtask

  initial begin : run_files
    logic [31:0] rate_plan[6];
    int unsigned files;
    int unsigned beats;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    max_rate            = DEFAULT_MAX_RATE;
    clear_parse();
    // The first run uses the reset value; the rest include both extremes.
    rate_plan = '{DEFAULT_MAX_RATE, 32'd1, 32'hFFFF_FFFF, 32'd48000, $urandom,
                  DEFAULT_MAX_RATE};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // An end marker before any byte: the RIFF tag is missing.
    pending_beats.push_back('{8'h00, 1'b1});
    // A wrong RIFF tag reports at once; the end marker after it is silent.
    file_img.delete();
    add_le(32'h5846_4952, 4);
    send_image(4);
    pending_beats.push_back('{8'hFF, 1'b0});
    pending_beats.push_back('{8'hFF, 1'b1});
    // An end marker inside the RIFF size field.
    file_img.delete();
    add_le(TAG_RIFF, 4);
    add_le(32'h0000_FFFF, 2);
    send_image(6);
    pending_beats.push_back('{8'h00, 1'b1});
    // A WAVE tag with its last bit wrong.
    file_img.delete();
    add_le(TAG_RIFF, 4);
    add_le(32'hFFFF_FFFF, 4);
    add_le(TAG_WAVE ^ 32'h8000_0000, 4);
    send_image(12);
    pending_beats.push_back('{8'h00, 1'b1});

    for (int p = 0; p < 6; p++) begin
      // Registers only change with the parser idle; the sender waits here
      // until every expected result has come back.
      if (p > 0) begin
        wait_idle();
        write_max_rate(rate_plan[p]);
      end
      files = 0;
      beats = 0;
      while (files < FILES_PER_RUN || beats < FILE_BEATS_PER_RUN) begin
        beats += add_file();
        files++;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("wav_header_parser_unit_tb passed");
    else
      $display("wav_header_parser_unit_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wavhp_pkg.sv
rtl/wavhp_in_if.sv
rtl/wavhp_out_if.sv
rtl/wavhp_check.sv
rtl/wav_header_parser_unit.sv
tb/wav_header_parser_unit_tb.sv
